// ----- rtl/lztd_pkg.sv -----
// Shared types and constants for the LZ77 token decoder.
package lztd_pkg;

  localparam int DEF_WINDOW_BYTES = 4096;
  localparam int DEF_MAX_MATCH    = 18;

  localparam int OFF_W  = 13;
  localparam int LEN_W  = 5;
  localparam int BYTE_W = 8;

  typedef struct packed {
    logic              new_stream;
    logic [OFF_W-1:0]  match_offset;
    logic [LEN_W-1:0]  match_length;
    logic [BYTE_W-1:0] literal_byte;
  } lztd_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_token;
    logic              bad_offset;
  } lztd_out_t;

  typedef struct packed {
    logic      valid;
    lztd_out_t data;
  } lztd_emit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_LIT,
    ST_ERR
  } lztd_state_t;

endpackage

// ----- rtl/lztd_ring_ram.sv -----
// History ring memory: one write port, one read port with registered read data.
module lztd_ring_ram import lztd_pkg::*; #(
  parameter int DEPTH = DEF_WINDOW_BYTES,
  parameter int AW    = $clog2(DEF_WINDOW_BYTES)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-before-write on a same-address collision; caller forwards
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/lztd_ctrl.sv -----
// Token sequencer: offset check, copy pointers, ring read/write and byte emit.
module lztd_ctrl import lztd_pkg::*; #(
  parameter int WINDOW_BYTES = DEF_WINDOW_BYTES,
  parameter int MAX_MATCH    = DEF_MAX_MATCH,
  parameter int PTR_W        = $clog2(DEF_WINDOW_BYTES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lztd_in_t          in_data,
  input  logic              slot_free,
  output lztd_emit_t        emit,
  output logic              ram_we,
  output logic [PTR_W-1:0]  ram_waddr,
  output logic [BYTE_W-1:0] ram_wdata,
  output logic              ram_re,
  output logic [PTR_W-1:0]  ram_raddr,
  input  logic [BYTE_W-1:0] ram_rd_data
);

  localparam int CNT_W = $clog2(WINDOW_BYTES + 1);
  localparam int CMP_W = (OFF_W > CNT_W) ? OFF_W : CNT_W;
  localparam int SUM_W = PTR_W + 1;

  lztd_state_t       state_r, state_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [BYTE_W-1:0] lit_r, lit_nxt;
  logic              fwd_r, fwd_nxt;
  logic [BYTE_W-1:0] fwd_byte_r, fwd_byte_nxt;

  logic [CNT_W-1:0]  cnt_base;
  logic [LEN_W-1:0]  len_sat;
  logic              bad;
  logic [SUM_W-1:0]  src_sum;
  logic [PTR_W-1:0]  src;
  logic [BYTE_W-1:0] copy_byte;
  logic [PTR_W-1:0]  wp_inc, rp_inc;
  logic [CNT_W-1:0]  cnt_inc;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(WINDOW_BYTES - 1)) r = '0;
    else                               r = p + 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      cnt_r   <= '0;
      fwd_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      cnt_r   <= cnt_nxt;
      fwd_r   <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rp_r       <= rp_nxt;
    rem_r      <= rem_nxt;
    lit_r      <= lit_nxt;
    fwd_byte_r <= fwd_byte_nxt;
  end

  always_comb begin
    cnt_base = in_data.new_stream ? '0 : cnt_r;
    if (int'(in_data.match_length) > MAX_MATCH) len_sat = LEN_W'(MAX_MATCH);
    else                                        len_sat = in_data.match_length;
    bad = (len_sat != '0) &&
          ((in_data.match_offset == '0) ||
           (CMP_W'(in_data.match_offset) > CMP_W'(cnt_base)));
    // wp - offset modulo window; offset is at most the window here
    src_sum = SUM_W'(wp_r) + SUM_W'(WINDOW_BYTES) - SUM_W'(in_data.match_offset);
    if (src_sum >= SUM_W'(WINDOW_BYTES)) src = PTR_W'(src_sum - SUM_W'(WINDOW_BYTES));
    else                                 src = PTR_W'(src_sum);
    copy_byte = fwd_r ? fwd_byte_r : ram_rd_data;
    wp_inc    = ptr_inc(wp_r);
    rp_inc    = ptr_inc(rp_r);
    cnt_inc   = (cnt_r == CNT_W'(WINDOW_BYTES)) ? cnt_r : cnt_r + 1'b1;
  end

  always_comb begin
    state_nxt    = state_r;
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    cnt_nxt      = cnt_r;
    rem_nxt      = rem_r;
    lit_nxt      = lit_r;
    fwd_nxt      = fwd_r;
    fwd_byte_nxt = fwd_byte_r;
    in_ready     = 1'b0;
    emit         = '0;
    ram_we       = 1'b0;
    ram_waddr    = wp_r;
    ram_wdata    = copy_byte;
    ram_re       = 1'b0;
    ram_raddr    = src;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cnt_nxt = cnt_base;
          lit_nxt = in_data.literal_byte;
          rem_nxt = len_sat;
          if (bad) begin
            state_nxt = ST_ERR;
          end else if (len_sat != '0) begin
            ram_re    = 1'b1;
            rp_nxt    = src;
            fwd_nxt   = 1'b0;
            state_nxt = ST_COPY;
          end else if (in_data.literal_byte != '0) begin
            state_nxt = ST_LIT;
          end
        end
      end

      ST_COPY: begin
        if (slot_free) begin
          emit.valid              = 1'b1;
          emit.data.out_byte      = copy_byte;
          emit.data.last_of_token = (rem_r == LEN_W'(1)) && (lit_r == '0);
          ram_we  = 1'b1;
          wp_nxt  = wp_inc;
          cnt_nxt = cnt_inc;
          rp_nxt  = rp_inc;
          rem_nxt = rem_r - 1'b1;
          if (rem_r != LEN_W'(1)) begin
            // next source is the slot written now when the offset is one
            ram_re       = 1'b1;
            ram_raddr    = rp_inc;
            fwd_nxt      = (rp_inc == wp_r);
            fwd_byte_nxt = copy_byte;
          end else if (lit_r != '0) begin
            state_nxt = ST_LIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_LIT: begin
        if (slot_free) begin
          emit.valid              = 1'b1;
          emit.data.out_byte      = lit_r;
          emit.data.last_of_token = 1'b1;
          ram_we    = 1'b1;
          ram_wdata = lit_r;
          wp_nxt    = wp_inc;
          cnt_nxt   = cnt_inc;
          state_nxt = ST_IDLE;
        end
      end

      ST_ERR: begin
        if (slot_free) begin
          emit.valid              = 1'b1;
          emit.data.last_of_token = 1'b1;
          emit.data.bad_offset    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lz77_token_decoder.sv -----
// LZ77 token decoder: the first byte of a token reaches out_ via the state and output
// registers. A token gives L copied bytes (L the saturated match length), then its literal
// if nonzero; a bad offset gives one error result. A new token waits until the current one
// is done. One byte per cycle while out_ is not stalled, set by the single ring read port.
// Reset (rst_n low, synchronous) clears the state, the write pointer, the produced count and
// the output valid flag; ring contents are left as they are and need no clearing pass.
module lz77_token_decoder import lztd_pkg::*; #(
  parameter int WINDOW_BYTES = DEF_WINDOW_BYTES,
  parameter int MAX_MATCH    = DEF_MAX_MATCH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lztd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output lztd_out_t out_data
);

  localparam int PTR_W = $clog2(WINDOW_BYTES);

  // ring memory ports
  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [PTR_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_rd_data;

  // output register: holds one result so the sequencer keeps moving
  // until the downstream side stalls it
  logic       out_valid_r, out_valid_nxt;
  lztd_out_t  out_data_r, out_data_nxt;
  logic       slot_free;
  lztd_emit_t emit;

  lztd_ring_ram #(
    .DEPTH (WINDOW_BYTES),
    .AW    (PTR_W)
  ) u_ring (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rd_data (ram_rd_data)
  );

  lztd_ctrl #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .MAX_MATCH    (MAX_MATCH),
    .PTR_W        (PTR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .slot_free   (slot_free),
    .emit        (emit),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rd_data (ram_rd_data)
  );

  // slot is free when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit.valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit.data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/lztd_checker.sv -----
// Port-level checks for the LZ77 token decoder, bound to the top level.
module lztd_checker import lztd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input lztd_out_t out_data
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // error result carries a zero byte and closes its token
  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_offset |-> out_data.out_byte == '0 && out_data.last_of_token)
    else $error("malformed error result");

  // no new token while the current one still has bytes to give
  a_no_accept_mid_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_token |-> !in_ready)
    else $error("token accepted before previous token finished");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind lz77_token_decoder lztd_checker u_lztd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- sim/tb_lz77_token_decoder.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the LZ77 token decoder: directed and random tokens, byte-level scoreboard.
module tb_lz77_token_decoder;
  import lztd_pkg::*;

  localparam int WIN        = DEF_WINDOW_BYTES;
  localparam int MAXM       = DEF_MAX_MATCH;
  localparam int CLK_HALF   = 5;
  localparam int IDLE_PCT   = 31;
  // cycles with no idling on either side
  localparam int QUIET_LO   = 3000;
  localparam int QUIET_HI   = 6000;
  // receiver hold-off: starts after this many output transactions, lasts HOLD_CYCLES
  localparam int HOLD_AFTER = 600;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int SAT_EXTRA  = 20;
  localparam int SAT_CAP    = 600;
  localparam int MIXED_ITEMS = 25;
  localparam longint TIMEOUT_NS = 64'd5_000_000;

  // Scoreboard: mirrors the decoder state and queues the expected byte stream.
  class lz_scoreboard;
    lztd_out_t   pending[$];
    logic [7:0]  ring [WIN];
    int unsigned wr_ptr;
    int unsigned produced_cnt;
    bit          saturated;
    int unsigned errors;
    int unsigned n_tokens;
    int unsigned n_bad;
    int unsigned n_checked;

    function new();
      foreach (ring[i]) ring[i] = 8'h00;
      wr_ptr       = 0;
      produced_cnt = 0;
      saturated    = 0;
      errors       = 0;
      n_tokens     = 0;
      n_bad        = 0;
      n_checked    = 0;
    endfunction

    function void push_byte(logic [7:0] b, bit last);
      lztd_out_t r;
      ring[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1) % WIN;
      if (produced_cnt < WIN) produced_cnt++;
      if (produced_cnt == WIN) saturated = 1;
      r.out_byte      = b;
      r.last_of_token = last;
      r.bad_offset    = 1'b0;
      pending.insert(pending.size(), r);
    endfunction

    // Called for every accepted input transaction.
    function void note_token(lztd_in_t t);
      int unsigned len;
      int unsigned off;
      int unsigned total;
      lztd_out_t   r;
      n_tokens++;
      if (t.new_stream) produced_cnt = 0;
      len = t.match_length;
      if (len > MAXM) len = MAXM;
      off = t.match_offset;
      if (len > 0 && (off == 0 || off > produced_cnt)) begin
        r.out_byte      = '0;
        r.last_of_token = 1'b1;
        r.bad_offset    = 1'b1;
        pending.insert(pending.size(), r);
        n_bad++;
        return;
      end
      total = len + ((t.literal_byte != 8'h00) ? 1 : 0);
      for (int k = 0; k < len; k++)
        push_byte(ring[(wr_ptr + WIN - off) % WIN], (k + 1) == total);
      if (t.literal_byte != 8'h00) push_byte(t.literal_byte, 1'b1);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    // Called for every accepted output transaction.
    function void check_byte(lztd_out_t got);
      lztd_out_t want;
      n_checked++;
      if (pending.size() == 0) begin
        note_error($sformatf("unexpected output: byte=%02h last=%0b bad=%0b",
                             got.out_byte, got.last_of_token, got.bad_offset));
        return;
      end
      want = pending.pop_front();
      if (got.out_byte !== want.out_byte || got.last_of_token !== want.last_of_token ||
          got.bad_offset !== want.bad_offset)
        note_error($sformatf({"mismatch: exp byte=%02h last=%0b bad=%0b,",
                              " got byte=%02h last=%0b bad=%0b"},
                             want.out_byte, want.last_of_token, want.bad_offset,
                             got.out_byte, got.last_of_token, got.bad_offset));
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  lztd_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  lztd_out_t out_data;

  int unsigned  cyc;
  lz_scoreboard sb;

  lz77_token_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // free-running cycle count, used to place the quiet window
  initial cyc = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_lz77_token_decoder: done, errors");
    $finish;
  end

  // Random idle decision, suppressed inside the quiet window.
  function automatic bit idle_roll();
    if (cyc >= QUIET_LO && cyc < QUIET_HI) return 1'b0;
    return ($urandom_range(99) < IDLE_PCT);
  endfunction

  function automatic lztd_in_t mk_token(bit ns, int unsigned off, int unsigned len,
                                         int unsigned lit);
    lztd_in_t t;
    t.new_stream   = ns;
    t.match_offset = 13'(off);
    t.match_length = 5'(len);
    t.literal_byte = 8'(lit);
    return t;
  endfunction

  // Token whose offset is legal for `have` bytes of history; length >= min_len when history
  // exists. Offsets lean toward tiny values (overlapping copies) and the full history depth.
  function automatic lztd_in_t legal_token(int unsigned have, int unsigned min_len);
    int unsigned off;
    int unsigned len;
    int unsigned lit;
    lit = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 255);
    if (have == 0) begin
      len = 0;
      off = $urandom_range(0, WIN);
    end else begin
      len = $urandom_range(min_len, 31);
      case ($urandom_range(3))
        0:       off = $urandom_range(1, (have < 4) ? have : 4);
        1:       off = have;
        default: off = $urandom_range(1, have);
      endcase
    end
    return mk_token(1'b0, off, len, lit);
  endfunction

  // Any length and literal the fields allow, offsets up to the window; stream restarts only when allowed.
  function automatic lztd_in_t noise_token(bit allow_ns);
    return mk_token(allow_ns ? 1'($urandom_range(1)) : 1'b0, $urandom_range(0, WIN),
                    $urandom_range(0, 31), $urandom_range(0, 255));
  endfunction

  // Offer one token; valid stays up until the transaction completes.
  task automatic send_token(input lztd_in_t tok);
    if (idle_roll()) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (idle_roll()) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_token(tok);
  endtask

  // Hand-picked tokens: field extremes, both bad-offset flavors, overlap, length clamp,
  // empty tokens, and stream restarts (one of them on a rejected token).
  task automatic run_directed();
    send_token(mk_token(1'b0, 0,    0,  8'h00));   // empty, no output
    send_token(mk_token(1'b1, 0,    0,  8'h41));   // literal only, new stream
    send_token(mk_token(1'b0, 5,    0,  8'hFF));   // offset ignored with zero length
    send_token(mk_token(1'b0, 0,    3,  8'h01));   // zero offset -> error
    send_token(mk_token(1'b0, 3,    2,  8'h10));   // offset past history -> error
    send_token(mk_token(1'b0, 1,    18, 8'h00));   // run-length style overlap
    send_token(mk_token(1'b0, 2,    31, 8'h80));   // length clamps to max match
    send_token(mk_token(1'b0, 39,   5,  8'h7F));   // offset equals history depth
    send_token(mk_token(1'b0, WIN,  1,  8'h02));   // max offset, too far -> error
    send_token(mk_token(1'b0, 44,   31, 8'h00));
    send_token(mk_token(1'b1, 1,    2,  8'h33));   // restart then error: count cleared
    send_token(mk_token(1'b0, 1,    1,  8'h22));   // nothing produced yet -> error
    send_token(mk_token(1'b0, 0,    0,  8'h55));
    send_token(mk_token(1'b0, 1,    1,  8'h00));   // single copy, no literal
    send_token(mk_token(1'b0, WIN,  0,  8'h12));
    send_token(mk_token(1'b1, 0,    0,  8'h00));   // empty token still restarts stream
    send_token(mk_token(1'b0, 0,    0,  8'hAA));
    send_token(mk_token(1'b0, WIN,  31, 8'hFF));   // all-ones length, max offset -> error
    send_token(mk_token(1'b0, 1,    17, 8'h01));
    send_token(mk_token(1'b0, 19,   18, 8'hFE));
  endtask

  // Receiver: random ready, one long hold-off so the decoder backs up into its input.
  initial begin
    int unsigned n_out;
    int unsigned hold_left;
    n_out     = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !idle_roll();
      end
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_byte(out_data);
        n_out++;
        if (n_out == HOLD_AFTER) hold_left = HOLD_CYCLES;
      end
    end
  end

  // Sender and run control.
  initial begin
    int unsigned n_sat;
    int unsigned extra;
    bit          ns;
    lztd_in_t    tok;
    sb       = new();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // One long stream of mostly long legal copies, kept going (up to SAT_CAP tokens) until the
    // history count saturates at the window size and a while past it, so offsets up to the full
    // window get exercised.
    send_token(mk_token(1'b1, 0, 0, $urandom_range(1, 255)));
    n_sat = 0;
    extra = 0;
    while (extra < SAT_EXTRA && n_sat < SAT_CAP) begin
      if ($urandom_range(99) < 85) tok = legal_token(sb.produced_cnt, 14);
      else tok = noise_token(1'b0);
      send_token(tok);
      n_sat++;
      if (sb.produced_cnt == WIN) extra++;
    end

    // Mixed tail: short streams with frequent restarts and some broken tokens.
    for (int i = 0; i < MIXED_ITEMS; i++) begin
      if ($urandom_range(99) < 85) begin
        ns  = ($urandom_range(7) == 0);
        tok = legal_token(ns ? 0 : sb.produced_cnt, 0);
        tok.new_stream = ns;
      end else begin
        tok = noise_token(1'b1);
      end
      send_token(tok);
    end
    in_valid <= 1'b0;

    // Let every expected transaction arrive, then watch for stragglers.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d tokens in, %0d rejected for bad offset, %0d output bytes compared",
             sb.n_tokens, sb.n_bad, sb.n_checked);
    $display("run: history window saturated: %s, mismatches: %0d",
             sb.saturated ? "yes" : "no", sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_lz77_token_decoder: done, clean");
    end else begin
      $display("tb_lz77_token_decoder: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/lztd_pkg.sv
rtl/lztd_ring_ram.sv
rtl/lztd_ctrl.sv
rtl/lz77_token_decoder.sv
rtl/lztd_checker.sv
sim/tb_lz77_token_decoder.sv
